[rtl/core/ggps_pkg.sv]
// Shared types, widths, register indexes and the arctangent table for the go-to-goal steering block.
package ggps_pkg;

   // Default number of CORDIC iterations (legal range 8 to 24)
   localparam int unsigned CORDIC_STEPS_DEF = 16;

   localparam int unsigned POS_W   = 16;   // Q5.10 position
   localparam int unsigned HEAD_W  = 15;   // Q2.12 heading
   localparam int unsigned DXY_W   = 17;   // goal minus position
   localparam int unsigned X_W     = 34;   // CORDIC x/y, scaled by 2^14
   localparam int unsigned Z_W     = 21;   // CORDIC angle, rad * 2^16
   localparam int unsigned ERR_W   = 22;   // bearing error, rad * 2^16
   localparam int unsigned DIST_W  = 18;   // unsigned Q8.10 distance
   localparam int unsigned ATAN_IW = 5;    // arctangent table index
   localparam int unsigned MA_W    = 33;   // multiplier operand a
   localparam int unsigned MB_W    = 18;   // multiplier operand b
   localparam int unsigned MP_W    = MA_W + MB_W;

   localparam logic signed [Z_W-1:0]  PI_Q16       = 21'sd205887;
   localparam logic signed [MB_W-1:0] INV_GAIN_Q16 = 18'sd39797;

   // CSR indexes
   localparam int unsigned CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_GOAL_X    = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_GOAL_Y    = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_LIN_GAIN  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_ANG_GAIN  = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_THRESHOLD = 3'd4;

   typedef struct packed {
      logic                    start;
      logic signed [DXY_W-1:0] dx;
      logic signed [DXY_W-1:0] dy;
      logic signed [Z_W-1:0]   z0;
   } cordic_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_sts_type;

   // round(atan(2^-i) * 2^16)
   function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IW-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = 21'sd51472;
         5'd1:    val = 21'sd30386;
         5'd2:    val = 21'sd16055;
         5'd3:    val = 21'sd8150;
         5'd4:    val = 21'sd4091;
         5'd5:    val = 21'sd2047;
         5'd6:    val = 21'sd1024;
         5'd7:    val = 21'sd512;
         5'd8:    val = 21'sd256;
         5'd9:    val = 21'sd128;
         5'd10:   val = 21'sd64;
         5'd11:   val = 21'sd32;
         5'd12:   val = 21'sd16;
         5'd13:   val = 21'sd8;
         5'd14:   val = 21'sd4;
         5'd15:   val = 21'sd2;
         5'd16:   val = 21'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[rtl/core/ggps_cordic.sv]
// Iterative vectoring CORDIC: one add/subtract-shift step per clock.
module ggps_cordic #(
   parameter int unsigned CORDIC_STEPS = ggps_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ggps_pkg::cordic_ctl_type              ctl,
   output ggps_pkg::cordic_sts_type              sts,
   output logic signed [ggps_pkg::X_W-1:0]       x_out,
   output logic signed [ggps_pkg::Z_W-1:0]       z_out
);
   import ggps_pkg::*;

   localparam int unsigned CntW = $clog2(CORDIC_STEPS);
   localparam logic [CntW-1:0] LastStep = CntW'(CORDIC_STEPS - 1);

   logic signed [X_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0] z_ff, z_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [ATAN_IW-1:0]    idx;
   logic signed [X_W-1:0] xs, ys;
   logic signed [Z_W-1:0] ang;

   assign idx = ATAN_IW'(cnt_ff);
   assign xs  = x_ff >>> idx;
   assign ys  = y_ff >>> idx;
   assign ang = atan_q16(idx);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         x_in    = {{(X_W-DXY_W-14){ctl.dx[DXY_W-1]}}, ctl.dx, 14'd0};
         y_in    = {{(X_W-DXY_W-14){ctl.dy[DXY_W-1]}}, ctl.dy, 14'd0};
         z_in    = ctl.z0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // rotate toward the x axis
         if (!y_ff[X_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign x_out    = x_ff;
   assign z_out    = z_ff;

endmodule

[rtl/core/ggps_mul.sv]
// Shared signed multiplier with a registered product.
module ggps_mul (
   input  logic                               clock,
   input  logic signed [ggps_pkg::MA_W-1:0]   a,
   input  logic signed [ggps_pkg::MB_W-1:0]   b,
   output logic signed [ggps_pkg::MP_W-1:0]   p
);
   import ggps_pkg::*;

   logic signed [MP_W-1:0] p_ff, p_in;

   assign p_in = MP_W'(a) * MP_W'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

[rtl/core/go_to_goal_proportional_steer.sv]
// Top level of the go-to-goal proportional steering controller.
//
// Usage:
//   req_* carries one pose transaction (x, y, heading). rsp_* returns one
//   command transaction per pose: linear speed, turn rate and the reached
//   flag. csr_* writes the goal, the two gains and the arrival threshold;
//   write only while no pose is in flight.
// Sequence:
//   req_tready is high only while the sequencer is idle, so a new pose is
//   taken only after the previous one has left the sequencer. A pose passes
//   through the start state, the CORDIC loop (one step per cycle), three
//   passes through the one shared multiplier (distance scaling, linear gain,
//   angular gain) and the output state, which holds while the output
//   register is still full.
// Stall:
//   the result sits in an output register; a new pose is accepted while it
//   waits, and the finished result of that pose waits for the register.
// Reset:
//   synchronous, active high; clears the sticky reached flag and loads the
//   register defaults (goal 1.0/1.0, gains 1.5 and 4.0, threshold 10 LSB).
module go_to_goal_proportional_steer #(
   parameter int unsigned CORDIC_STEPS = ggps_pkg::CORDIC_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: pos_x[15:0], pos_y[31:16], heading[46:32], zero pad [47]
   input  logic [47:0]                      req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: linear_speed[15:0], turn_rate[31:16]
   output logic [31:0]                      rsp_tdata,
   // tuser: reached[0]
   output logic                             rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [ggps_pkg::CSR_AW-1:0]      csr_addr,
   input  logic [15:0]                      csr_wdata
);
   import ggps_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_CORD  = 4'd2;
   localparam logic [3:0] S_MDIST = 4'd3;
   localparam logic [3:0] S_DIST  = 4'd4;
   localparam logic [3:0] S_MLIN  = 4'd5;
   localparam logic [3:0] S_LIN   = 4'd6;
   localparam logic [3:0] S_MTURN = 4'd7;
   localparam logic [3:0] S_TURN  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   // configuration registers
   logic signed [POS_W-1:0] goal_x_ff, goal_y_ff;
   logic [15:0]             lin_gain_ff, ang_gain_ff, thresh_ff;

   logic [3:0]              state_ff, state_in;
   logic                    done_flag_ff, done_flag_in;

   // per-pose working registers
   logic signed [DXY_W-1:0]  dx_ff, dy_ff, dx_in, dy_in;
   logic signed [Z_W-1:0]    z0_ff, z0_in;
   logic signed [HEAD_W-1:0] head_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic [DIST_W-1:0]        dist_ff;
   logic [15:0]              lin_ff;
   logic signed [15:0]       turn_ff;

   // output register
   logic                     rsp_valid_ff;
   logic [15:0]              rsp_lin_ff;
   logic [15:0]              rsp_turn_ff;
   logic                     rsp_reached_ff;

   logic signed [POS_W-1:0]  pos_x, pos_y;
   logic signed [DXY_W-1:0]  dx_raw, dy_raw;
   logic                     req_take;

   cordic_ctl_type           cordic_ctl;
   cordic_sts_type           cordic_sts;
   logic signed [X_W-1:0]    cordic_x;
   logic signed [Z_W-1:0]    cordic_z;

   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [MP_W-1:0]   mul_p;
   logic signed [MP_W-1:0]   rnd_dist, rnd_lin, rnd_turn;
   logic signed [MP_W-19:0]  turn_full;
   logic signed [ERR_W-1:0]  err_in;

   assign pos_x    = req_tdata[15:0];
   assign pos_y    = req_tdata[31:16];
   assign req_tready = (state_ff == S_IDLE);
   assign req_take = req_tvalid && req_tready;

   // offset to goal; fold the left half plane by pi before vectoring
   assign dx_raw = DXY_W'(goal_x_ff) - DXY_W'(pos_x);
   assign dy_raw = DXY_W'(goal_y_ff) - DXY_W'(pos_y);

   always_comb begin
      dx_in = dx_raw;
      dy_in = dy_raw;
      z0_in = '0;
      if (dx_raw[DXY_W-1]) begin
         dx_in = -dx_raw;
         dy_in = -dy_raw;
         z0_in = dy_raw[DXY_W-1] ? -PI_Q16 : PI_Q16;
      end
   end

   assign cordic_ctl.start = (state_ff == S_START);
   assign cordic_ctl.dx    = dx_ff;
   assign cordic_ctl.dy    = dy_ff;
   assign cordic_ctl.z0    = z0_ff;

   ggps_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .ctl   (cordic_ctl),
      .sts   (cordic_sts),
      .x_out (cordic_x),
      .z_out (cordic_z)
   );

   // operand steering for the shared multiplier
   always_comb begin
      case (state_ff)
         S_MDIST: begin
            mul_a = cordic_x[X_W-1] ? '0 : {1'b0, cordic_x[MA_W-2:0]};
            mul_b = INV_GAIN_Q16;
         end
         S_MLIN: begin
            mul_a = {{(MA_W-DIST_W){1'b0}}, dist_ff};
            mul_b = {{(MB_W-16){1'b0}}, lin_gain_ff};
         end
         S_MTURN: begin
            mul_a = {{(MA_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            mul_b = {{(MB_W-16){1'b0}}, ang_gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   ggps_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   // bearing error, heading rescaled from Q2.12 to rad * 2^16
   assign err_in = {cordic_z[Z_W-1], cordic_z} - {{3{head_ff[HEAD_W-1]}}, head_ff, 4'd0};

   // rounding adds; products for distance and speed are non-negative
   assign rnd_dist  = mul_p + (MP_W'(1) <<< 29);
   assign rnd_lin   = mul_p + MP_W'(2048);
   assign rnd_turn  = mul_p + (MP_W'(1) <<< 17);
   assign turn_full = rnd_turn[MP_W-1:18];

   always_comb begin
      state_in     = state_ff;
      done_flag_in = done_flag_ff;
      case (state_ff)
         S_IDLE:  if (req_take) state_in = S_START;
         S_START: state_in = S_CORD;
         S_CORD:  if (cordic_sts.done) state_in = S_MDIST;
         S_MDIST: state_in = S_DIST;
         S_DIST: begin
            state_in = S_MLIN;
            // sticky arrival; zero threshold never matches
            if (rnd_dist[47:30] < {2'b00, thresh_ff}) done_flag_in = 1'b1;
         end
         S_MLIN:  state_in = S_LIN;
         S_LIN:   state_in = S_MTURN;
         S_MTURN: state_in = S_TURN;
         S_TURN:  state_in = S_OUT;
         S_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         z0_ff   <= z0_in;
         head_ff <= req_tdata[46:32];
      end
      if (state_ff == S_MDIST) err_ff <= err_in;
      if (state_ff == S_DIST) dist_ff <= rnd_dist[47:30];
      if (state_ff == S_LIN) begin
         lin_ff <= (|rnd_lin[MP_W-1:28]) ? 16'hFFFF : rnd_lin[27:12];
      end
      if (state_ff == S_TURN) begin
         if (turn_full > 33'sd32767)
            turn_ff <= 16'sh7FFF;
         else if (turn_full < -33'sd32768)
            turn_ff <= 16'sh8000;
         else
            turn_ff <= turn_full[15:0];
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_lin_ff     <= done_flag_ff ? '0 : lin_ff;
         rsp_turn_ff    <= done_flag_ff ? '0 : turn_ff;
         rsp_reached_ff <= done_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_flag_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         goal_x_ff    <= 16'sd1024;
         goal_y_ff    <= 16'sd1024;
         lin_gain_ff  <= 16'd6144;
         ang_gain_ff  <= 16'd16384;
         thresh_ff    <= 16'd10;
      end else begin
         state_ff     <= state_in;
         done_flag_ff <= done_flag_in;
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_addr)
               CSR_GOAL_X:    goal_x_ff   <= csr_wdata;
               CSR_GOAL_Y:    goal_y_ff   <= csr_wdata;
               CSR_LIN_GAIN:  lin_gain_ff <= csr_wdata;
               CSR_ANG_GAIN:  ang_gain_ff <= csr_wdata;
               CSR_THRESHOLD: thresh_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_turn_ff, rsp_lin_ff};
   assign rsp_tuser  = rsp_reached_ff;

   // once reached, commands are zero
   a_reached_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("reached result carries nonzero speed");

   // reached flag is sticky until reset
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_flag_ff |=> done_flag_ff)
      else $error("reached flag cleared without reset");

   // CORDIC completion only while the sequencer waits for it
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cordic_sts.done |-> state_ff == S_CORD)
      else $error("CORDIC done outside wait state");

   // no new pose while the CORDIC is iterating
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !cordic_sts.busy)
      else $error("pose accepted while CORDIC busy");

endmodule
